[hw/rtl/tree_bitmap_delta_frame_encoder_core_assert.svh]
// Assertion macros shared by the frame encoder RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef TREE_BITMAP_DELTA_FRAME_ENCODER_CORE_ASSERT_SVH
`define TREE_BITMAP_DELTA_FRAME_ENCODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBDFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBDFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/tbdfe_pkg.sv]
// Shared types and constants of the frame encoder.
// Used by the RAM, the walk sequencer and the top level; depends on nothing.
package tbdfe_pkg;

   localparam int LINES_USED_DEF  = 60;
   localparam int LINES_MAX       = 64;
   localparam int PIXELS_PER_LINE = 64;
   localparam int GROUP_SIZE      = 8;
   localparam int BYTE_W          = 8;
   localparam int POS_W           = 12;
   localparam int COUNT_W         = 13;
   localparam int LINE_ADDR_W     = 6;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] cur_value;
      logic [BYTE_W-1:0] prev_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_byte;
      logic              last_byte;
   } rsp_type;

   // Position of the stream walk in the mask hierarchy
   typedef enum logic [4:0] {
      PH_BAND    = 5'b00001,
      PH_LINE    = 5'b00010,
      PH_GROUP   = 5'b00100,
      PH_PIXMASK = 5'b01000,
      PH_VALUE   = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } seq_type;

   // Mask level searched by the shared find-first-set unit
   typedef enum logic [3:0] {
      LV_PIXEL = 4'b0001,
      LV_GROUP = 4'b0010,
      LV_LINE  = 4'b0100,
      LV_BAND  = 4'b1000
   } level_type;

   typedef struct packed {
      logic [2:0] band;
      logic [2:0] line;
      logic [2:0] group;
      logic [2:0] pixel;
   } walk_pos_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic out_free;
   } walk_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic last;
   } walk_stat_type;

endpackage

[hw/rtl/tbdfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on tbdfe_pkg for default sizes.
module tbdfe_ram #(
   parameter int WIDTH  = tbdfe_pkg::BYTE_W,
   parameter int DEPTH  = tbdfe_pkg::LINES_MAX,
   parameter int ADDR_W = tbdfe_pkg::LINE_ADDR_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tbdfe_ffs.sv]
// Find-first-set unit: lowest set bit of an 8-bit mask at or above a start bit.
// Shared by all levels of the stream walk; depends on nothing.
module tbdfe_ffs (
   input  logic [7:0] mask,
   input  logic [3:0] start,
   output logic       found,
   output logic [2:0] index
);

   logic [7:0] masked;

   // Drop bits below the start position
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         masked[b] = mask[b] && (4'(b) >= start);
      end
   end

   // Priority encode, lowest bit wins; index is zero when nothing is set
   always_comb begin
      index = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (masked[b]) begin
            index = 3'(b);
         end
      end
   end

   assign found = |masked;

endmodule

[hw/rtl/tbdfe_walk.sv]
// Stream walk sequencer: steps through band, line, group and pixel masks
// with one shared find-first-set unit. Depends on tbdfe_pkg and tbdfe_ffs.
module tbdfe_walk (
   input  logic                     clock,
   input  logic                     reset,
   input  tbdfe_pkg::walk_ctrl_type ctrl,
   input  logic [7:0]               band_mask,
   input  logic [7:0]               line_mask,
   input  logic [7:0]               group_mask,
   input  logic [7:0]               pixel_mask,
   input  logic [7:0]               pixel_value,
   output tbdfe_pkg::walk_pos_type  pos,
   output tbdfe_pkg::walk_stat_type stat,
   output logic [7:0]               out_byte
);

   tbdfe_pkg::seq_type      seq_ff, seq_in;
   tbdfe_pkg::phase_type    phase_ff, phase_in, next_phase;
   tbdfe_pkg::level_type    level_ff, level_in, level_up, start_level;
   tbdfe_pkg::walk_pos_type pos_ff, pos_in;

   logic [7:0] scan_mask;
   logic [2:0] scan_cur;
   logic [3:0] scan_start;
   logic       scan_found;
   logic [2:0] scan_index;
   logic       phase_value;
   logic       at_band;
   logic       scanning;
   logic       final_step;
   logic       end_stream;

   // Select the mask and the current index of the level under search
   always_comb begin
      scan_mask  = band_mask;
      scan_cur   = pos_ff.band;
      next_phase = tbdfe_pkg::PH_LINE;
      level_up   = tbdfe_pkg::LV_BAND;
      unique case (level_ff)
         tbdfe_pkg::LV_PIXEL: begin
            scan_mask  = pixel_mask;
            scan_cur   = pos_ff.pixel;
            next_phase = tbdfe_pkg::PH_VALUE;
            level_up   = tbdfe_pkg::LV_GROUP;
         end
         tbdfe_pkg::LV_GROUP: begin
            scan_mask  = group_mask;
            scan_cur   = pos_ff.group;
            next_phase = tbdfe_pkg::PH_PIXMASK;
            level_up   = tbdfe_pkg::LV_LINE;
         end
         tbdfe_pkg::LV_LINE: begin
            scan_mask  = line_mask;
            scan_cur   = pos_ff.line;
            next_phase = tbdfe_pkg::PH_GROUP;
            level_up   = tbdfe_pkg::LV_BAND;
         end
         tbdfe_pkg::LV_BAND: begin
            scan_mask  = band_mask;
            scan_cur   = pos_ff.band;
            next_phase = tbdfe_pkg::PH_LINE;
            level_up   = tbdfe_pkg::LV_BAND;
         end
         default: begin
            scan_mask  = band_mask;
         end
      endcase
   end

   assign phase_value = (phase_ff == tbdfe_pkg::PH_VALUE);
   // In the value phase search past the current entry, otherwise from bit zero
   assign scan_start  = phase_value ? ({1'b0, scan_cur} + 4'd1) : 4'd0;

   tbdfe_ffs u_ffs (
      .mask  (scan_mask),
      .start (scan_start),
      .found (scan_found),
      .index (scan_index)
   );

   assign at_band    = (level_ff == tbdfe_pkg::LV_BAND);
   assign scanning   = (seq_ff == tbdfe_pkg::ST_SCAN);
   assign final_step = scan_found || at_band || !phase_value;
   assign end_stream = !scan_found && at_band;

   // Pick the first level to search and the byte to emit from the phase
   always_comb begin
      start_level = tbdfe_pkg::LV_BAND;
      out_byte    = band_mask;
      unique case (phase_ff)
         tbdfe_pkg::PH_BAND: begin
            start_level = tbdfe_pkg::LV_BAND;
            out_byte    = band_mask;
         end
         tbdfe_pkg::PH_LINE: begin
            start_level = tbdfe_pkg::LV_LINE;
            out_byte    = line_mask;
         end
         tbdfe_pkg::PH_GROUP: begin
            start_level = tbdfe_pkg::LV_GROUP;
            out_byte    = group_mask;
         end
         tbdfe_pkg::PH_PIXMASK: begin
            start_level = tbdfe_pkg::LV_PIXEL;
            out_byte    = pixel_mask;
         end
         tbdfe_pkg::PH_VALUE: begin
            start_level = tbdfe_pkg::LV_PIXEL;
            out_byte    = pixel_value;
         end
         default: begin
            start_level = tbdfe_pkg::LV_BAND;
         end
      endcase
   end

   // Advance the sequencer; climb a level on a miss, commit on a hit, end the stream on a band miss
   always_comb begin
      seq_in   = seq_ff;
      phase_in = phase_ff;
      level_in = level_ff;
      pos_in   = pos_ff;
      unique case (seq_ff)
         tbdfe_pkg::ST_IDLE: begin
            if (ctrl.start) begin
               seq_in   = tbdfe_pkg::ST_SCAN;
               level_in = start_level;
            end
         end
         tbdfe_pkg::ST_SCAN: begin
            if (!final_step) begin
               level_in = level_up;
            end else if (ctrl.out_free) begin
               seq_in = tbdfe_pkg::ST_IDLE;
               if (end_stream) begin
                  phase_in = tbdfe_pkg::PH_BAND;
                  pos_in   = '0;
               end else begin
                  phase_in = next_phase;
                  unique case (level_ff)
                     tbdfe_pkg::LV_PIXEL: pos_in.pixel = scan_index;
                     tbdfe_pkg::LV_GROUP: pos_in.group = scan_index;
                     tbdfe_pkg::LV_LINE:  pos_in.line  = scan_index;
                     tbdfe_pkg::LV_BAND:  pos_in.band  = scan_index;
                     default:             pos_in       = pos_ff;
                  endcase
               end
            end
         end
         default: begin
            seq_in = tbdfe_pkg::ST_IDLE;
         end
      endcase
      // Drop the walk when a new frame starts
      if (ctrl.clear) begin
         seq_in   = tbdfe_pkg::ST_IDLE;
         phase_in = tbdfe_pkg::PH_BAND;
         level_in = tbdfe_pkg::LV_BAND;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= tbdfe_pkg::ST_IDLE;
         phase_ff <= tbdfe_pkg::PH_BAND;
         level_ff <= tbdfe_pkg::LV_BAND;
         pos_ff   <= '0;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         pos_ff   <= pos_in;
      end
   end

   assign pos       = pos_ff;
   assign stat.busy = scanning;
   assign stat.done = scanning && final_step && ctrl.out_free;
   assign stat.last = end_stream;

endmodule

[hw/rtl/tree_bitmap_delta_frame_encoder_core.sv]
// Hierarchical bitmap delta-frame encoder, top level.
// Input channel (req_): one transaction is either a load of one pixel pair
// (current and previous byte, line-major, 64 pixels per line, LINES_USED lines)
// or a pull of the next byte of the packed stream. Result channel (rsp_): one
// transaction per pull that yields a byte, with last_byte on the frame's final
// byte. A pull before the frame is complete is taken and gives no result.
// Loads may come every cycle while the input is not stalled. A pull that
// yields a byte holds the input stalled while the walk sequencer runs the
// shared find-first-set unit: for a mask byte the search stays at its own
// level, and for a pixel byte it can climb from pixel to group, line and band
// mask. The result register loads at the end of that search, and the next
// transaction is taken once the sequencer is back in idle. If the receiver
// stalls, the search holds its last step until the result register frees up.
// Reset clears all flags, the load position and the walk; the RAMs need no
// clearing pass, since mask entries are rewritten whole while a frame loads.
// A load while a stream is pending drops that stream and starts a new frame.
// Depends on tbdfe_pkg, tbdfe_ram, tbdfe_walk and the assertion macro header.
`include "tree_bitmap_delta_frame_encoder_core_assert.svh"

module tree_bitmap_delta_frame_encoder_core #(
   parameter int LINES_USED = tbdfe_pkg::LINES_USED_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tbdfe_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tbdfe_pkg::rsp_type rsp_data
);

   localparam int PIX_DEPTH  = LINES_USED * tbdfe_pkg::PIXELS_PER_LINE;
   localparam int GRP_DEPTH  = LINES_USED * tbdfe_pkg::GROUP_SIZE;
   localparam int PIX_AW     = $clog2(PIX_DEPTH);
   localparam int GRP_AW     = $clog2(GRP_DEPTH);
   localparam int LINE_AW    = (LINES_USED > 1) ? $clog2(LINES_USED) : 1;
   localparam logic [tbdfe_pkg::COUNT_W-1:0] FRAME_PIXELS =
      tbdfe_pkg::COUNT_W'(PIX_DEPTH);

   // Frame state
   logic [tbdfe_pkg::POS_W-1:0] load_pos_ff, load_pos_in;
   logic                        ready_ff, ready_in;
   logic [7:0]                  band_flags_ff, band_flags_in;
   logic [7:0]                  line_flags_ff [8];
   logic [7:0]                  line_flags_in [8];
   logic [7:0]                  pix_acc_ff, pix_acc_in;
   logic [7:0]                  line_acc_ff, line_acc_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   tbdfe_pkg::rsp_type rsp_ff, rsp_in;

   logic                        accept;
   logic                        load_fire;
   logic                        pull_fire;
   logic                        restart;
   logic                        changed;
   logic                        frame_end;
   logic [tbdfe_pkg::POS_W-1:0] pos;
   logic [tbdfe_pkg::COUNT_W-1:0] count_next;
   logic [7:0]                  changed_bit;

   tbdfe_pkg::walk_ctrl_type walk_ctrl;
   tbdfe_pkg::walk_stat_type walk_stat;
   tbdfe_pkg::walk_pos_type  walk_pos;
   logic [11:0]              walk_addr;
   logic [7:0]               walk_byte;
   logic [7:0]               group_rd;
   logic [7:0]               change_rd;
   logic [7:0]               pixel_rd;

   // Assertion terms
   logic                     frame_cleared;
   logic                     pos_restarted;
   logic                     rsp_quiet;

   assign accept    = req_valid && !req_stall;
   assign load_fire = accept && (req_data.kind == tbdfe_pkg::KIND_LOAD);
   assign pull_fire = accept && (req_data.kind == tbdfe_pkg::KIND_PULL);
   assign restart   = load_fire && ready_ff;
   assign frame_end = walk_stat.done && walk_stat.last;
   assign req_stall = walk_stat.busy;

   // A load over a pending stream becomes pixel zero of a new frame
   assign pos         = restart ? '0 : load_pos_ff;
   assign changed     = (req_data.cur_value != req_data.prev_value);
   assign changed_bit = {7'd0, changed};
   assign count_next  = {1'b0, pos} + tbdfe_pkg::COUNT_W'(1);

   // Build the group and line masks whole, so each RAM entry is rewritten
   assign pix_acc_in  = ((pos[2:0] == 3'd0) ? 8'd0 : pix_acc_ff) | (changed_bit << pos[2:0]);
   assign line_acc_in = ((pos[5:0] == 6'd0) ? 8'd0 : line_acc_ff) | (changed_bit << pos[5:3]);

   // Update load position, stream flag, band and line flags
   always_comb begin
      load_pos_in   = load_pos_ff;
      ready_in      = ready_ff;
      band_flags_in = band_flags_ff;
      for (int i = 0; i < 8; i++) begin
         line_flags_in[i] = line_flags_ff[i];
      end
      if (load_fire) begin
         if (restart) begin
            band_flags_in = '0;
            for (int i = 0; i < 8; i++) begin
               line_flags_in[i] = '0;
            end
         end
         line_flags_in[pos[11:9]] = line_flags_in[pos[11:9]] | (changed_bit << pos[8:6]);
         band_flags_in            = band_flags_in | (changed_bit << pos[11:9]);
         load_pos_in              = count_next[tbdfe_pkg::POS_W-1:0];
         ready_in                 = (count_next >= FRAME_PIXELS);
      end else if (frame_end) begin
         load_pos_in   = '0;
         ready_in      = 1'b0;
         band_flags_in = '0;
         for (int i = 0; i < 8; i++) begin
            line_flags_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff   <= '0;
         ready_ff      <= 1'b0;
         band_flags_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            line_flags_ff[i] <= '0;
         end
      end else begin
         load_pos_ff   <= load_pos_in;
         ready_ff      <= ready_in;
         band_flags_ff <= band_flags_in;
         for (int i = 0; i < 8; i++) begin
            line_flags_ff[i] <= line_flags_in[i];
         end
      end
   end

   // Accumulators carry the partial masks of the group and line being loaded
   always_ff @(posedge clock) begin
      if (load_fire) begin
         pix_acc_ff  <= pix_acc_in;
         line_acc_ff <= line_acc_in;
      end
   end

   // Mask and pixel stores; reads are issued on the pull that starts a walk
   assign walk_addr = {walk_pos.band, walk_pos.line, walk_pos.group, walk_pos.pixel};

   tbdfe_ram #(
      .WIDTH  (tbdfe_pkg::BYTE_W),
      .DEPTH  (PIX_DEPTH),
      .ADDR_W (PIX_AW)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (pos[PIX_AW-1:0]),
      .wr_data (req_data.cur_value),
      .rd_en   (walk_ctrl.start),
      .rd_addr (walk_addr[PIX_AW-1:0]),
      .rd_data (pixel_rd)
   );

   tbdfe_ram #(
      .WIDTH  (tbdfe_pkg::BYTE_W),
      .DEPTH  (GRP_DEPTH),
      .ADDR_W (GRP_AW)
   ) u_change_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (pos[3 +: GRP_AW]),
      .wr_data (pix_acc_in),
      .rd_en   (walk_ctrl.start),
      .rd_addr (walk_addr[3 +: GRP_AW]),
      .rd_data (change_rd)
   );

   tbdfe_ram #(
      .WIDTH  (tbdfe_pkg::BYTE_W),
      .DEPTH  (LINES_USED),
      .ADDR_W (LINE_AW)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (pos[6 +: LINE_AW]),
      .wr_data (line_acc_in),
      .rd_en   (walk_ctrl.start),
      .rd_addr (walk_addr[6 +: LINE_AW]),
      .rd_data (group_rd)
   );

   // Walk sequencer
   assign walk_ctrl.start    = pull_fire && ready_ff;
   assign walk_ctrl.clear    = restart;
   assign walk_ctrl.out_free = !rsp_valid_ff || !rsp_stall;

   tbdfe_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (walk_ctrl),
      .band_mask   (band_flags_ff),
      .line_mask   (line_flags_ff[walk_pos.band]),
      .group_mask  (group_rd),
      .pixel_mask  (change_rd),
      .pixel_value (pixel_rd),
      .pos         (walk_pos),
      .stat        (walk_stat),
      .out_byte    (walk_byte)
   );

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (walk_stat.done) begin
         rsp_valid_in       = 1'b1;
         rsp_in.stream_byte = walk_byte;
         rsp_in.last_byte   = walk_stat.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Terms for the checks below
   assign frame_cleared = !ready_ff && (load_pos_ff == '0) && (band_flags_ff == '0);
   assign pos_restarted = (load_pos_ff == tbdfe_pkg::POS_W'(1));
   assign rsp_quiet     = !walk_stat.done && !rsp_valid_ff;

   `TBDFE_ASSERT_SAME(a_walk_needs_frame, clock, reset, walk_stat.busy, ready_ff, "walk no frame")
   `TBDFE_ASSERT_NEXT(a_end_clears_frame, clock, reset, frame_end, frame_cleared, "not cleared")
   `TBDFE_ASSERT_NEXT(a_restart_position, clock, reset, restart, pos_restarted, "no restart")
   `TBDFE_ASSERT_NEXT(a_result_from_walk, clock, reset, rsp_quiet, !rsp_valid_ff, "stray result")

endmodule
